// ===== sv/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// widths, latencies, register codes and shared types of the stereo distance
// spatialiser
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ROOT_BITS = 16;

  localparam int POS_W     = 15;
  localparam int RIGHT_W   = 18;
  localparam int GAIN_W    = 10;
  localparam int MASTER_W  = 8;
  localparam int VOL_W     = 9;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  localparam int ONE     = 1 << FRAC_BITS;
  localparam int VOL_MAX = (1 << VOL_W) - 1;

  // offset, squared length, root and quotient widths
  localparam int D_W    = POS_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int ROOT_W = ROOT_BITS;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int N_W    = (Q_W + 1 > D_W) ? Q_W + 1 : D_W;

  // tail arithmetic widths
  localparam int P_W    = RIGHT_W + N_W;
  localparam int DOT_W  = P_W - FRAC_BITS + 2;
  localparam int DIST_W = ROOT_W + GAIN_W;
  localparam int ATT_W  = DIST_W + 2;
  localparam int PS_W   = DOT_W + 1;
  localparam int SC_W   = ATT_W + PS_W - FRAC_BITS;
  localparam int VM_W   = MASTER_W + 1 + SC_W - FRAC_BITS;

  // pipeline depths
  localparam int FRONT_LAT = 3;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int MIX_LAT   = 4;
  localparam int PIPE_LAT  = FRONT_LAT + ROOT_BITS + DIV_LAT + MIX_LAT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LISTENER_X,
    CFG_LISTENER_Y,
    CFG_LISTENER_Z,
    CFG_RIGHT_X,
    CFG_RIGHT_Y,
    CFG_RIGHT_Z
  } cfg_idx_e;

  typedef struct packed {
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic signed [D_W-1:0]  dz;
    logic [GAIN_W-1:0]      gain;
    logic [MASTER_W-1:0]    master;
  } sds_side_t;

  typedef struct packed {
    sds_side_t           side;
    logic [ROOT_W-1:0]   len;
  } sds_norm_t;

endpackage

`default_nettype wire

// ===== sv/sds_if.sv =====
// ----------------------------------------------------------------------------
// sds_in_if / sds_out_if
// source beat and volume beat channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sds_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sds_pkg::POS_W-1:0]       source_x;
  logic signed [sds_pkg::POS_W-1:0]       source_y;
  logic signed [sds_pkg::POS_W-1:0]       source_z;
  logic [sds_pkg::GAIN_W-1:0]             distance_gain;
  logic [sds_pkg::MASTER_W-1:0]           master_volume;

  modport source (output valid, source_x, source_y, source_z, distance_gain,
                  master_volume, input ready);
  modport sink (input valid, source_x, source_y, source_z, distance_gain,
                master_volume, output ready);
endinterface

interface sds_out_if;
  logic                         valid;
  logic                         ready;
  logic [sds_pkg::VOL_W-1:0]    left_vol;
  logic [sds_pkg::VOL_W-1:0]    right_vol;
  logic                         audible;

  modport source (output valid, left_vol, right_vol, audible, input ready);
  modport sink (input valid, left_vol, right_vol, audible, output ready);
endinterface

`default_nettype wire

// ===== sv/sds_isqrt.sv =====
// ----------------------------------------------------------------------------
// sds_isqrt
// pipelined bitwise integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sds_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [sds_pkg::SQ_W-1:0]    val_i,
  output      logic [sds_pkg::ROOT_W-1:0]  root_o
);
  import sds_pkg::*;

  localparam int T_W = SQ_W + 2;

  logic [ROOT_W-1:0] g_q [ROOT_BITS];
  logic [SQ_W-1:0]   v_q [ROOT_BITS];

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    localparam int K = ROOT_BITS - 1 - s;
    logic [ROOT_W-1:0] g_in;
    logic [SQ_W-1:0]   v_in;
    logic [T_W-1:0]    t;
    logic              take;

    if (s == 0) begin : g_first
      assign g_in = '0;
      assign v_in = val_i;
    end else begin : g_next
      assign g_in = g_q[s-1];
      assign v_in = v_q[s-1];
    end

    assign t    = (T_W'(g_in) << (K + 1)) + (T_W'(1) << (2 * K));
    assign take = T_W'(v_in) >= t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[s] <= take ? (g_in | (ROOT_W'(1) << K)) : g_in;
        v_q[s] <= take ? (v_in - t[SQ_W-1:0]) : v_in;
      end
    end
  end

  assign root_o = g_q[ROOT_BITS-1];

endmodule

`default_nettype wire

// ===== sv/sds_div.sv =====
// ----------------------------------------------------------------------------
// sds_div
// pipelined restoring divider, offset scaled to Q16 over the length,
// truncating toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module sds_div (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [sds_pkg::D_W-1:0]           mag_i,
  input  wire logic                              neg_i,
  input  wire logic [sds_pkg::ROOT_W-1:0]        den_i,
  output      logic signed [sds_pkg::N_W-1:0]    quo_o
);
  import sds_pkg::*;

  logic [ROOT_W-1:0] r_q   [Q_W];
  logic [Q_W-1:0]    q_q   [Q_W];
  logic [ROOT_W-1:0] den_q [Q_W];
  logic              neg_q [Q_W];
  logic signed [N_W-1:0] quo_q;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [ROOT_W:0]   trial;
    logic [ROOT_W-1:0] den_in;
    logic [Q_W-1:0]    q_in;
    logic              neg_in;
    logic              take;

    if (s == 0) begin : g_first
      assign trial  = (ROOT_W+1)'(mag_i);
      assign den_in = den_i;
      assign q_in   = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign trial  = {r_q[s-1], 1'b0};
      assign den_in = den_q[s-1];
      assign q_in   = q_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign take = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= take ? ROOT_W'(trial - {1'b0, den_in}) : ROOT_W'(trial);
        q_q[s]   <= {q_in[Q_W-2:0], take};
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[Q_W-1] ? -$signed(N_W'(q_q[Q_W-1])) : $signed(N_W'(q_q[Q_W-1]));
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/sds_mix.sv =====
// ----------------------------------------------------------------------------
// sds_mix
// dot product with the right vector, distance attenuation and per-side
// volume scaling, four register stages
// ----------------------------------------------------------------------------
`default_nettype none

module sds_mix (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [sds_pkg::N_W-1:0]      nx_i,
  input  wire logic signed [sds_pkg::N_W-1:0]      ny_i,
  input  wire logic signed [sds_pkg::N_W-1:0]      nz_i,
  input  wire logic [sds_pkg::ROOT_W-1:0]          len_i,
  input  wire logic [sds_pkg::GAIN_W-1:0]          gain_i,
  input  wire logic [sds_pkg::MASTER_W-1:0]        master_i,
  input  wire logic signed [sds_pkg::RIGHT_W-1:0]  right_x_i,
  input  wire logic signed [sds_pkg::RIGHT_W-1:0]  right_y_i,
  input  wire logic signed [sds_pkg::RIGHT_W-1:0]  right_z_i,
  output      logic signed [sds_pkg::VM_W-1:0]     vol_l_o,
  output      logic signed [sds_pkg::VM_W-1:0]     vol_r_o
);
  import sds_pkg::*;

  // stage 1: products
  logic signed [P_W-1:0]   px_q, py_q, pz_q;
  logic [DIST_W-1:0]       dist_q;
  logic [MASTER_W-1:0]     m1_q;
  // stage 2: dot and attenuation
  logic signed [ATT_W-1:0] att_q;
  logic signed [PS_W-1:0]  psr_q, psl_q;
  logic [MASTER_W-1:0]     m2_q;
  // stage 3: scales
  logic signed [SC_W-1:0]  scr_q, scl_q;
  logic [MASTER_W-1:0]     m3_q;
  // stage 4: volumes
  logic signed [VM_W-1:0]  vr_q, vl_q;

  logic signed [DOT_W-1:0]       dot_d;
  logic signed [ATT_W+PS_W-1:0]  prr_d, prl_d;
  logic signed [MASTER_W:0]      ms_d;
  logic signed [MASTER_W+SC_W:0] pvr_d, pvl_d;

  always_comb begin
    dot_d = DOT_W'(px_q >>> FRAC_BITS) + DOT_W'(py_q >>> FRAC_BITS)
          + DOT_W'(pz_q >>> FRAC_BITS);
    prr_d = att_q * psr_q;
    prl_d = att_q * psl_q;
    ms_d  = $signed({1'b0, m3_q});
    pvr_d = ms_d * scr_q;
    pvl_d = ms_d * scl_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= right_x_i * nx_i;
      py_q   <= right_y_i * ny_i;
      pz_q   <= right_z_i * nz_i;
      dist_q <= DIST_W'(len_i) * DIST_W'(gain_i);
      m1_q   <= master_i;

      att_q  <= ATT_W'(ONE) - $signed({2'b00, dist_q});
      psr_q  <= PS_W'(ONE) + PS_W'(dot_d);
      psl_q  <= PS_W'(ONE) - PS_W'(dot_d);
      m2_q   <= m1_q;

      scr_q  <= SC_W'(prr_d >>> FRAC_BITS);
      scl_q  <= SC_W'(prl_d >>> FRAC_BITS);
      m3_q   <= m2_q;

      vr_q   <= VM_W'(pvr_d >>> FRAC_BITS);
      vl_q   <= VM_W'(pvl_d >>> FRAC_BITS);
    end
  end

  assign vol_l_o = vl_q;
  assign vol_r_o = vr_q;

endmodule

`default_nettype wire

// ===== sv/stereo_distance_spatialiser.sv =====
// ----------------------------------------------------------------------------
// stereo_distance_spatialiser
// left and right volumes of one sound source from its offset to the listener
//
//   channel   dir  beat
//   snd_i     in   source x/y/z, distance gain, master volume
//   vol_o     out  left volume, right volume, audible flag
//   cfg       in   listener position and right vector, write only
//
// one beat per cycle unless stalled; a source beat passes through 3 offset and
// square stages, 16 root stages, 18 divider stages, 4 mixing stages and the
// output register. all stages advance together whenever the output register
// is empty or taken, so a stalled sink holds every beat in place. reset
// clears the valid bits and sets the listener to the origin, right vector +x.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_distance_spatialiser (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  sds_in_if.sink                                 snd_i,
  sds_out_if.source                              vol_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [sds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sds_pkg::CFG_W-1:0]         cfg_data_i
);
  import sds_pkg::*;

  logic signed [POS_W-1:0]   lst_x_q, lst_y_q, lst_z_q;
  logic signed [RIGHT_W-1:0] rgt_x_q, rgt_y_q, rgt_z_q;

  logic en;
  logic vld_q [PIPE_LAT];

  sds_side_t              s0_q, s1_q, s2_q;
  logic [SQ_W-1:0]        sqx_q, sqy_q, sqz_q, sq_q;
  sds_side_t              sd_q [ROOT_BITS];
  sds_norm_t              dv_q [DIV_LAT];
  logic [ROOT_W-1:0]      root;
  sds_side_t              rs;
  logic signed [N_W-1:0]  qx, qy, qz, nx, ny, nz;
  logic signed [VM_W-1:0] vl, vr;
  logic [VOL_W-1:0]       lv_d, rv_d;
  logic [VOL_W-1:0]       lv_q, rv_q;
  logic                   aud_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lst_x_q <= '0;
      lst_y_q <= '0;
      lst_z_q <= '0;
      rgt_x_q <= RIGHT_W'(ONE);
      rgt_y_q <= '0;
      rgt_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LISTENER_X: lst_x_q <= cfg_data_i[POS_W-1:0];
        CFG_LISTENER_Y: lst_y_q <= cfg_data_i[POS_W-1:0];
        CFG_LISTENER_Z: lst_z_q <= cfg_data_i[POS_W-1:0];
        CFG_RIGHT_X:    rgt_x_q <= cfg_data_i[RIGHT_W-1:0];
        CFG_RIGHT_Y:    rgt_y_q <= cfg_data_i[RIGHT_W-1:0];
        CFG_RIGHT_Z:    rgt_z_q <= cfg_data_i[RIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  assign en          = !vld_q[PIPE_LAT-1] || vol_o.ready;
  assign snd_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= snd_i.valid;
      for (int i = 1; i < PIPE_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // offset, squares, squared length
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.dx     <= D_W'(snd_i.source_x) - D_W'(lst_x_q);
      s0_q.dy     <= D_W'(snd_i.source_y) - D_W'(lst_y_q);
      s0_q.dz     <= D_W'(snd_i.source_z) - D_W'(lst_z_q);
      s0_q.gain   <= snd_i.distance_gain;
      s0_q.master <= snd_i.master_volume;

      sqx_q <= $unsigned(SQ_W'(s0_q.dx * s0_q.dx));
      sqy_q <= $unsigned(SQ_W'(s0_q.dy * s0_q.dy));
      sqz_q <= $unsigned(SQ_W'(s0_q.dz * s0_q.dz));
      s1_q  <= s0_q;

      sq_q  <= sqx_q + sqy_q + sqz_q;
      s2_q  <= s1_q;
    end
  end

  sds_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (sq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= s2_q;
      for (int i = 1; i < ROOT_BITS; i++) sd_q[i] <= sd_q[i-1];
      dv_q[0] <= '{side: sd_q[ROOT_BITS-1], len: root};
      for (int i = 1; i < DIV_LAT; i++) dv_q[i] <= dv_q[i-1];
    end
  end

  assign rs = sd_q[ROOT_BITS-1];

  sds_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (rs.dx[D_W-1] ? D_W'(-rs.dx) : D_W'(rs.dx)),
    .neg_i (rs.dx[D_W-1]),
    .den_i (root),
    .quo_o (qx)
  );

  sds_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (rs.dy[D_W-1] ? D_W'(-rs.dy) : D_W'(rs.dy)),
    .neg_i (rs.dy[D_W-1]),
    .den_i (root),
    .quo_o (qy)
  );

  sds_div u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (rs.dz[D_W-1] ? D_W'(-rs.dz) : D_W'(rs.dz)),
    .neg_i (rs.dz[D_W-1]),
    .den_i (root),
    .quo_o (qz)
  );

  // zero length keeps the raw offset
  always_comb begin
    if (dv_q[DIV_LAT-1].len == '0) begin
      nx = N_W'(dv_q[DIV_LAT-1].side.dx);
      ny = N_W'(dv_q[DIV_LAT-1].side.dy);
      nz = N_W'(dv_q[DIV_LAT-1].side.dz);
    end else begin
      nx = qx;
      ny = qy;
      nz = qz;
    end
  end

  sds_mix u_mix (
    .clk_i     (clk_i),
    .en_i      (en),
    .nx_i      (nx),
    .ny_i      (ny),
    .nz_i      (nz),
    .len_i     (dv_q[DIV_LAT-1].len),
    .gain_i    (dv_q[DIV_LAT-1].side.gain),
    .master_i  (dv_q[DIV_LAT-1].side.master),
    .right_x_i (rgt_x_q),
    .right_y_i (rgt_y_q),
    .right_z_i (rgt_z_q),
    .vol_l_o   (vl),
    .vol_r_o   (vr)
  );

  // clamp to the field
  always_comb begin
    if (vl < 0) begin
      lv_d = '0;
    end else if (vl > VM_W'(VOL_MAX)) begin
      lv_d = VOL_W'(VOL_MAX);
    end else begin
      lv_d = vl[VOL_W-1:0];
    end
    if (vr < 0) begin
      rv_d = '0;
    end else if (vr > VM_W'(VOL_MAX)) begin
      rv_d = VOL_W'(VOL_MAX);
    end else begin
      rv_d = vr[VOL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lv_q  <= lv_d;
      rv_q  <= rv_d;
      aud_q <= (lv_d != '0) || (rv_d != '0);
    end
  end

  assign vol_o.valid     = vld_q[PIPE_LAT-1];
  assign vol_o.left_vol  = lv_q;
  assign vol_o.right_vol = rv_q;
  assign vol_o.audible   = aud_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the stereo distance spatialiser against a behavioural volume
// predictor: a directed table of corner beats, then random source beats over
// several listener settings, with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sds_pkg::*;

  typedef struct packed {
    logic [VOL_W-1:0] left_vol;
    logic [VOL_W-1:0] right_vol;
    logic             audible;
  } vol_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [GAIN_W-1:0]       gain;
    logic [MASTER_W-1:0]     master;
    logic                    pinned;
    vol_beat_t               vol;
  } snd_row_t;

  localparam int N_ROWS = 14;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  sds_in_if  snd ();
  sds_out_if vol ();

  stereo_distance_spatialiser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snd_i      (snd),
    .vol_o      (vol),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  longint listener_pos[3];
  longint right_vec[3];

  vol_beat_t vol_expected_q[$];
  snd_row_t  pinned_q[$];
  int        fail_count;
  bit        quiet;
  int        stall_left;
  int        run_left;

  snd_row_t rows[N_ROWS] = '{
    '{15'sd0, 15'sd0, 15'sd0, 10'd0, 8'd255, 1'b1, '{9'd255, 9'd255, 1'b1}},
    '{15'sd100, 15'sd0, 15'sd0, 10'd0, 8'd200, 1'b1, '{9'd0, 9'd400, 1'b1}},
    '{-15'sd100, 15'sd0, 15'sd0, 10'd0, 8'd200, 1'b1, '{9'd400, 9'd0, 1'b1}},
    '{15'sd0, 15'sd0, 15'sd0, 10'd0, 8'd0, 1'b1, '{9'd0, 9'd0, 1'b0}},
    '{15'sd16383, 15'sd0, 15'sd0, 10'd1023, 8'd255, 1'b1, '{9'd0, 9'd0, 1'b0}},
    '{-15'sd16384, -15'sd16384, -15'sd16384, 10'd1023, 8'd255, 1'b0, '0},
    '{15'sd16383, 15'sd16383, 15'sd16383, 10'd0, 8'd255, 1'b0, '0},
    '{15'sd0, 15'sd3, 15'sd4, 10'd1000, 8'd128, 1'b0, '0},
    '{15'sd0, 15'sd7, 15'sd0, 10'd1, 8'd255, 1'b0, '0},
    '{15'sd1, 15'sd1, 15'sd1, 10'd1023, 8'd255, 1'b0, '0},
    '{-15'sd1, 15'sd0, 15'sd0, 10'd1023, 8'd255, 1'b0, '0},
    '{15'sd0, 15'sd0, -15'sd16384, 10'd0, 8'd1, 1'b0, '0},
    '{15'sd5, -15'sd5, 15'sd0, 10'd0, 8'd255, 1'b0, '0},
    '{15'sd30, 15'sd40, 15'sd0, 10'd3, 8'd170, 1'b0, '0}
  };

  function automatic logic [VOL_W-1:0] side_volume(longint master, longint att,
                                                   longint pan);
    longint scale;
    longint v;
    scale = (att * pan) >>> FRAC_BITS;
    v = (master * scale) >>> FRAC_BITS;
    if (v < 0) v = 0;
    if (v > VOL_MAX) v = VOL_MAX;
    return v[VOL_W-1:0];
  endfunction

  function automatic vol_beat_t spatialise(snd_row_t s);
    longint d[3];
    longint rem, root, b, t, span, dot, att, one;
    vol_beat_t r;
    one = longint'(1) << FRAC_BITS;
    d[0] = longint'(s.x) - listener_pos[0];
    d[1] = longint'(s.y) - listener_pos[1];
    d[2] = longint'(s.z) - listener_pos[2];
    rem = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    root = 0;
    for (int k = ROOT_BITS - 1; k >= 0; k--) begin
      b = longint'(1) << k;
      t = ((root << 1) + b) << k;
      if (rem >= t) begin
        root += b;
        rem -= t;
      end
    end
    if (root != 0) begin
      for (int i = 0; i < 3; i++) d[i] = (d[i] * one) / root;
    end
    span = root * longint'(s.gain);
    dot = 0;
    for (int i = 0; i < 3; i++) dot += (right_vec[i] * d[i]) >>> FRAC_BITS;
    att = one - span;
    r.right_vol = side_volume(longint'(s.master), att, one + dot);
    r.left_vol = side_volume(longint'(s.master), att, one - dot);
    r.audible = (r.left_vol != 0) || (r.right_vol != 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // volume channel: accept beats, with random stall bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      vol.ready <= 1'b1;
    end else if (stall_left > 0) begin
      vol.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left > 0) begin
      vol.ready <= 1'b1;
      run_left <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      vol.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      vol.ready <= 1'b1;
      run_left <= $urandom_range(0, 20);
    end
  end

  // queue the expected beat for every source beat, check every volume beat
  always @(posedge clk_i) begin
    snd_row_t s;
    vol_beat_t want;
    if (rst_ni && snd.valid && snd.ready) begin
      s = pinned_q.pop_front();
      want = s.pinned ? s.vol : spatialise(s);
      vol_expected_q.push_back(want);
    end
    if (rst_ni && vol.valid && vol.ready) begin
      if (vol_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = vol_expected_q.pop_front();
        if (vol.left_vol !== want.left_vol)
          report_mismatch("left_vol", vol.left_vol, want.left_vol);
        if (vol.right_vol !== want.right_vol)
          report_mismatch("right_vol", vol.right_vol, want.right_vol);
        if (vol.audible !== want.audible)
          report_mismatch("audible", vol.audible, want.audible);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LISTENER_X: listener_pos[0] = longint'($signed(data[POS_W-1:0]));
      CFG_LISTENER_Y: listener_pos[1] = longint'($signed(data[POS_W-1:0]));
      CFG_LISTENER_Z: listener_pos[2] = longint'($signed(data[POS_W-1:0]));
      CFG_RIGHT_X:    right_vec[0] = longint'($signed(data[RIGHT_W-1:0]));
      CFG_RIGHT_Y:    right_vec[1] = longint'($signed(data[RIGHT_W-1:0]));
      CFG_RIGHT_Z:    right_vec[2] = longint'($signed(data[RIGHT_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic drain();
    while (vol_expected_q.size() != 0 || pinned_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_beat(snd_row_t s, bit allow_idle);
    if (allow_idle && !quiet && $urandom_range(0, 5) == 0) begin
      snd.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    snd.valid <= 1'b1;
    snd.source_x <= s.x;
    snd.source_y <= s.y;
    snd.source_z <= s.z;
    snd.distance_gain <= s.gain;
    snd.master_volume <= s.master;
    pinned_q.push_back(s);
    do @(posedge clk_i); while (!snd.ready);
  endtask

  function automatic logic signed [POS_W-1:0] near_pos(longint centre, int spread);
    longint p;
    p = centre + $signed($urandom_range(0, 2 * spread)) - spread;
    return p[POS_W-1:0];
  endfunction

  function automatic snd_row_t random_beat();
    snd_row_t s;
    int spread;
    s = '0;
    if ($urandom_range(0, 9) < 3) begin
      s.x = POS_W'($urandom);
      s.y = POS_W'($urandom);
      s.z = POS_W'($urandom);
      s.gain = GAIN_W'($urandom);
    end else begin
      spread = ($urandom_range(0, 3) == 0) ? 2 : 400;
      s.x = near_pos(listener_pos[0], spread);
      s.y = near_pos(listener_pos[1], spread);
      s.z = near_pos(listener_pos[2], spread);
      s.gain = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 1023))
                                           : GAIN_W'($urandom_range(0, 40));
    end
    s.master = MASTER_W'($urandom);
    return s;
  endfunction

  initial begin
    logic [CFG_W-1:0] setting[3];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    snd.valid = 1'b0;
    snd.source_x = '0;
    snd.source_y = '0;
    snd.source_z = '0;
    snd.distance_gain = '0;
    snd.master_volume = '0;
    vol.ready = 1'b0;
    quiet = 1'b0;
    stall_left = 0;
    run_left = 0;
    fail_count = 0;
    listener_pos = '{0, 0, 0};
    right_vec = '{65536, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i], 1'b1);
    snd.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: setting = '{18'h03fff, 18'h03fff, 18'h03fff};
        1: setting = '{18'h04000, 18'h04000, 18'h04000};
        2: setting = '{18'h1ffff, 18'h1ffff, 18'h1ffff};
        3: setting = '{18'h20000, 18'h20000, 18'h20000};
        default: setting = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom)};
      endcase
      for (int a = 0; a < 3; a++) begin
        write_reg(cfg_idx_e'(CFG_LISTENER_X + a),
                  (phase < 2) ? setting[a] :
                  ((phase < 4) ? CFG_W'($urandom_range(0, 255)) : CFG_W'($urandom)));
      end
      for (int a = 0; a < 3; a++) begin
        write_reg(cfg_idx_e'(CFG_RIGHT_X + a),
                  (phase >= 2) ? setting[a] : CFG_W'($urandom_range(0, 65536)));
      end
      write_reg(CFG_IDX_W'(CFG_RIGHT_Z + 1), CFG_W'($urandom));
      write_reg(CFG_IDX_W'(CFG_RIGHT_Z + 2), CFG_W'($urandom));
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      if (phase == 8) quiet = 1'b1;
      for (int n = 0; n < 143; n++) begin
        send_beat(random_beat(), 1'b1);
        if (phase == 5 && n == 60) begin
          snd.valid <= 1'b0;
          drain();
        end
      end
      snd.valid <= 1'b0;
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
